[hw/rtl/pcs_pkg.sv]
// pcs_pkg: shared types and constants for the puct child selector
// no dependencies
`default_nettype none
package pcs_pkg;
   localparam int unsigned ActionWidth = 10;
   localparam int unsigned PriorWidth  = 16;
   localparam int unsigned VisitWidth  = 24;
   localparam int unsigned SumWidth    = 40;
   localparam int unsigned IndexWidth  = 8;
   localparam int unsigned ScoreWidth  = 32;
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned SqrtWidth   = 24;
   localparam int unsigned CsrIdxWidth = 1;

   localparam logic [CsrIdxWidth-1:0] CSR_EXPLORATION_WEIGHT = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RANK_BY_VISITS     = 1'd1;
   localparam logic [WeightWidth-1:0] WEIGHT_RESET           = 16'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_MUL,
      ST_DIV_MEAN,
      ST_DIV_U,
      ST_RANK
   } state_type;
endpackage
`default_nettype wire

[hw/rtl/puct_child_selector.sv]
// puct_child_selector: running best-child search over one node's children
// depends on pcs_pkg; bit-serial sqrt, shift-add multiply and restoring dividers
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  request  | req_* fields                           | start & !busy
//  result   | rsp_best_action/index/score            | rsp_valid, one cycle
//  csr      | csr_index, csr_data                    | csr_valid & csr_ready
//
// after a transfer busy stays high through the sqrt (first child of a node only), the
// multiply, the two divides and the rank step in puct mode; visits mode keeps only the
// sqrt and rank steps. the result strobe comes in the cycle after the last child's rank
// step. reset is synchronous and clears control and the running best. the receiver
// cannot stall results.
`default_nettype none
module puct_child_selector #(
   parameter int unsigned MAX_CHILDREN = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [9:0]  req_child_action,
   input  wire logic [15:0] req_prior,
   input  wire logic [23:0] req_visit_count,
   input  wire logic signed [39:0] req_value_sum,
   input  wire logic [23:0] req_parent_visits,
   input  wire logic        req_last_child,
   output logic             rsp_valid,
   output logic [9:0]       rsp_best_action,
   output logic [7:0]       rsp_best_index,
   output logic signed [31:0] rsp_best_score,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pcs_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int unsigned CntBits  = $clog2(MAX_CHILDREN + 1);
   localparam int unsigned CntWidth = (CntBits > 8) ? CntBits : 8;
   localparam int unsigned ProdW = 56; // 16+16+24
   localparam int unsigned DivW  = 64;

   pcs_pkg::state_type state_ff, state_in;

   logic [15:0] weight_ff;
   logic        rank_ff;

   // latched item
   logic [9:0]  action_ff;
   logic [15:0] prior_ff;
   logic [23:0] visits_ff;
   logic signed [39:0] sum_ff;
   logic        last_ff;

   logic [CntWidth-1:0] count_ff, count_in;
   logic [23:0] psqrt_ff, psqrt_in;
   logic        have_ff, have_in;
   logic signed [31:0] best_score_ff, best_score_in;
   logic [9:0]  best_action_ff, best_action_in;
   logic [7:0]  best_index_ff, best_index_in;

   // shared shift datapath
   logic [6:0]  step_ff, step_in;
   logic [47:0] rad_ff, rad_in;     // sqrt radicand
   logic [25:0] rem_s_ff, rem_s_in; // sqrt remainder
   logic [ProdW-1:0] acc_ff, acc_in;   // product accumulator
   logic [ProdW-1:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [DivW:0]   rem_ff, rem_in;
   logic [DivW-1:0] dvd_ff, dvd_in;
   logic signed [41:0] mean_ff, mean_in;
   logic [ProdW-1:0] prod_ff, prod_in;

   logic        go;
   logic        rsp_valid_in;
   logic [25:0] s_trial;
   logic [DivW:0] r_shift;
   logic [DivW:0] divisor;
   logic [39:0] sum_abs;
   logic signed [65:0] total;
   logic signed [31:0] score;
   logic        take;

   assign go        = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= pcs_pkg::WEIGHT_RESET;
         rank_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pcs_pkg::CSR_EXPLORATION_WEIGHT: weight_ff <= csr_data;
            pcs_pkg::CSR_RANK_BY_VISITS:     rank_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcs_pkg::ST_IDLE:
            if (go) begin
               // the parent root is taken at the first child of a node in either mode
               if (count_ff == '0) state_in = pcs_pkg::ST_SQRT;
               else if (rank_ff) state_in = pcs_pkg::ST_RANK;
               else state_in = pcs_pkg::ST_MUL;
            end
         pcs_pkg::ST_SQRT:
            if (step_ff == 7'd23) state_in = rank_ff ? pcs_pkg::ST_RANK : pcs_pkg::ST_MUL;
         pcs_pkg::ST_MUL:      if (step_ff == 7'd31) state_in = pcs_pkg::ST_DIV_MEAN;
         pcs_pkg::ST_DIV_MEAN: if (step_ff == 7'd63) state_in = pcs_pkg::ST_DIV_U;
         pcs_pkg::ST_DIV_U:    if (step_ff == 7'd63) state_in = pcs_pkg::ST_RANK;
         pcs_pkg::ST_RANK:     state_in = pcs_pkg::ST_IDLE;
         default:              state_in = pcs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy         = (state_ff != pcs_pkg::ST_IDLE);
      rsp_valid_in = (state_ff == pcs_pkg::ST_RANK) && last_ff;
   end

   assign s_trial = {rem_s_ff[23:0], rad_ff[47:46]} - {psqrt_ff, 2'b01};
   assign divisor = (state_ff == pcs_pkg::ST_DIV_MEAN) ?
                    {41'd0, visits_ff} : {{(DivW-44){1'b0}}, {1'b0, visits_ff} + 25'd1, 20'd0};
   assign r_shift = {rem_ff[DivW-1:0], dvd_ff[DivW-1]};
   assign sum_abs = sum_ff[39] ? ~sum_ff + 40'd1 : sum_ff;

   assign total = (state_ff == pcs_pkg::ST_RANK && !rank_ff) ?
                  66'(mean_ff) + $signed({10'd0, prod_ff}) : '0;
   always_comb begin
      if (rank_ff) score = {8'd0, visits_ff};
      else if (total > 66'sd2147483647) score = 32'sh7fffffff;
      else if (total < -66'sd2147483648) score = 32'sh80000000;
      else score = total[31:0];
   end
   assign take = (count_ff < CntWidth'(MAX_CHILDREN)) && (!have_ff || score > best_score_ff);

   always_comb begin
      step_in = step_ff + 7'd1;
      rad_in = rad_ff; rem_s_in = rem_s_ff; psqrt_in = psqrt_ff;
      acc_in = acc_ff; mcand_in = mcand_ff; mplier_in = mplier_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvd_in = dvd_ff;
      mean_in = mean_ff; prod_in = prod_ff;
      count_in = count_ff; have_in = have_ff;
      best_score_in = best_score_ff; best_action_in = best_action_ff;
      best_index_in = best_index_ff;
      case (state_ff)
         pcs_pkg::ST_IDLE: begin
            step_in  = '0;
            rad_in   = {req_parent_visits, 24'd0};
            rem_s_in = '0;
            if (count_ff == '0) psqrt_in = '0;
            acc_in    = '0;
            mcand_in  = {40'd0, req_prior};
            mplier_in = '0;
         end
         pcs_pkg::ST_SQRT: begin
            // one result bit per cycle, two radicand bits
            rad_in = {rad_ff[45:0], 2'b00};
            if (!s_trial[25]) begin
               rem_s_in = s_trial;
               psqrt_in = {psqrt_ff[22:0], 1'b1};
            end else begin
               rem_s_in = {rem_s_ff[23:0], rad_ff[47:46]};
               psqrt_in = {psqrt_ff[22:0], 1'b0};
            end
            if (step_ff == 7'd23) step_in = '0;
         end
         pcs_pkg::ST_MUL: begin
            // prior * weight * sqrt: multiplier bit per cycle over the parent sqrt
            if (step_ff == 7'd0) begin
               mplier_in = {8'd0, psqrt_ff};
               mcand_in  = {24'd0, 32'(prior_ff) * 32'(weight_ff)};
               step_in   = 7'd1;
               acc_in    = '0;
            end else begin
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = {mcand_ff[ProdW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[31:1]};
            end
            if (step_ff == 7'd31) begin
               prod_in = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
               step_in = '0;
               rem_in  = '0;
               quo_in  = '0;
               dvd_in  = {24'd0, sum_abs};
            end
         end
         pcs_pkg::ST_DIV_MEAN, pcs_pkg::ST_DIV_U: begin
            dvd_in = {dvd_ff[DivW-2:0], 1'b0};
            if (r_shift >= divisor) begin
               rem_in = r_shift - divisor;
               quo_in = {quo_ff[DivW-2:0], 1'b1};
            end else begin
               rem_in = r_shift;
               quo_in = {quo_ff[DivW-2:0], 1'b0};
            end
            if (step_ff == 7'd63) begin
               if (state_ff == pcs_pkg::ST_DIV_MEAN) begin
                  if (visits_ff == '0) mean_in = '0;
                  else if (sum_ff < 0) mean_in = -$signed({1'b0, quo_in[40:0]});
                  else mean_in = $signed({1'b0, quo_in[40:0]});
                  dvd_in = {8'd0, prod_ff};
               end else begin
                  prod_in = quo_in[ProdW-1:0];
               end
               step_in = '0;
               rem_in  = '0;
               quo_in  = '0;
            end
         end
         pcs_pkg::ST_RANK: begin
            if (take) begin
               best_score_in  = score;
               best_action_in = action_ff;
               best_index_in  = count_ff[7:0];
               have_in        = 1'b1;
            end
            if (count_ff < CntWidth'(MAX_CHILDREN)) count_in = count_ff + 1'b1;
            if (last_ff) begin
               count_in = '0; have_in = 1'b0; best_score_in = '0;
               best_action_in = '0; best_index_in = '0; psqrt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pcs_pkg::ST_IDLE;
         count_ff       <= '0;
         have_ff        <= 1'b0;
         psqrt_ff       <= '0;
         best_score_ff  <= '0;
         best_action_ff <= '0;
         best_index_ff  <= '0;
         rsp_valid      <= 1'b0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         have_ff        <= have_in;
         psqrt_ff       <= psqrt_in;
         best_score_ff  <= best_score_in;
         best_action_ff <= best_action_in;
         best_index_ff  <= best_index_in;
         rsp_valid      <= rsp_valid_in;
         step_ff        <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in; rem_s_ff <= rem_s_in;
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvd_ff <= dvd_in;
      mean_ff <= mean_in; prod_ff <= prod_in;
      if (go) begin
         action_ff <= req_child_action;
         prior_ff  <= req_prior;
         visits_ff <= req_visit_count;
         sum_ff    <= req_value_sum;
         last_ff   <= req_last_child;
      end
      // result shows the winner including the last child
      if (rsp_valid_in) begin
         rsp_best_action <= take ? action_ff : best_action_ff;
         rsp_best_index  <= take ? count_ff[7:0] : best_index_ff;
         rsp_best_score  <= take ? score : best_score_ff;
      end
   end
endmodule
`default_nettype wire
